[design/bhe_pkg.sv]
// Shared types and constants of the bi-histogram equalizer.
// Command and status structs between controller and datapath, item kinds, CSR indexes.
// No dependencies.
`timescale 1ns / 1ps

package bhe_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_COUNT = 2'd1;
   localparam logic [1:0] KIND_BUILD = 2'd2;
   localparam logic [1:0] KIND_MAP   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_SPLIT_MODE  = 1'b0;
   localparam logic CSR_SPLIT_LEVEL = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // capture the item pixel
      logic clr_hist;    // empty histogram and part counts
      logic hist_rd;     // read bin of the item pixel
      logic cnt_wr;      // write incremented bin, bump part count
      logic map_rd;      // read map entry of the item pixel
      logic rsp_load;    // move map entry into the result register
      logic part_init;   // set bounds and total of one part
      logic part_sel;    // 0 first part, 1 upper part of split mode
      logic bin_rd;      // read bin at the build level
      logic cdf_acc;     // add bin to running cdf
      logic mul;         // product of span and cdf
      logic div_init;    // load divider
      logic div_step;    // one quotient bit
      logic map_wr;      // write map entry, advance level
   } bhe_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic x_last;      // build level is the upper bound of the part
      logic div_last;    // last quotient bit in progress
      logic has_part1;   // split mode with a non-empty upper part
   } bhe_status_type;

endpackage

[design/bhe_dpath.sv]
// Datapath of the bi-histogram equalizer: histogram and map memories, part counts,
// cdf accumulator, multiplier and bit-serial divider.
// Depends on bhe_pkg.
`timescale 1ns / 1ps

module bhe_dpath #(
   parameter int COUNT_BITS  = 22,
   parameter int GRAY_LEVELS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr,
   input  logic                    csr_index,
   input  logic [7:0]              csr_data,
   input  logic [7:0]              req_pixel,
   input  bhe_pkg::bhe_cmd_type    cmd,
   output bhe_pkg::bhe_status_type status,
   output logic [7:0]              rsp_mapped_pixel
);
   import bhe_pkg::*;

   localparam int LVL_BITS  = $clog2(GRAY_LEVELS);
   localparam int CDF_BITS  = COUNT_BITS + LVL_BITS;
   localparam int PROD_BITS = CDF_BITS + LVL_BITS;
   localparam int N_BITS    = COUNT_BITS + 1;
   localparam int STEP_BITS = (LVL_BITS > 1) ? $clog2(LVL_BITS) : 1;
   localparam logic [7:0]          TOP_PIX = 8'(GRAY_LEVELS - 1);
   localparam logic [LVL_BITS-1:0] TOP_LVL = LVL_BITS'(GRAY_LEVELS - 1);

   logic                  mode_ff;
   logic [7:0]            level_ff;
   logic [LVL_BITS-1:0]   split_lvl;
   logic [LVL_BITS-1:0]   pix_in;
   logic [LVL_BITS-1:0]   pix_ff;

   logic [COUNT_BITS-1:0] bin_mem [GRAY_LEVELS];
   logic [GRAY_LEVELS-1:0] bin_vld_ff;
   logic [COUNT_BITS-1:0] bin_rd_ff;
   logic                  bin_rd_vld_ff;
   logic [COUNT_BITS-1:0] bin_eff;
   logic [COUNT_BITS-1:0] bin_inc;
   logic [LVL_BITS-1:0]   bin_addr;
   logic [COUNT_BITS-1:0] low_ff;
   logic [COUNT_BITS-1:0] high_ff;

   logic [7:0]            map_mem [GRAY_LEVELS];
   logic [7:0]            map_rd_ff;
   logic [7:0]            rsp_pixel_ff;

   logic [LVL_BITS-1:0]   lo_ff;
   logic [LVL_BITS-1:0]   hi_ff;
   logic [N_BITS-1:0]     n_ff;
   logic [LVL_BITS-1:0]   x_ff;
   logic [LVL_BITS-1:0]   span;
   logic [CDF_BITS-1:0]   cdf_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [CDF_BITS-1:0]   prod_top;
   logic [N_BITS-1:0]     rem_ff;
   logic [LVL_BITS-1:0]   frac_ff;
   logic [LVL_BITS-1:0]   q_ff;
   logic                  ovf_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [N_BITS:0]       trial;
   logic [LVL_BITS-1:0]   map_val;

   // Clamp levels to the top gray level
   assign split_lvl = (level_ff > TOP_PIX) ? TOP_LVL : level_ff[LVL_BITS-1:0];
   assign pix_in    = (req_pixel > TOP_PIX) ? TOP_LVL : req_pixel[LVL_BITS-1:0];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         level_ff <= 8'd128;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_SPLIT_MODE:  mode_ff  <= csr_data[0];
            CSR_SPLIT_LEVEL: level_ff <= csr_data;
            default:         mode_ff  <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) pix_ff <= pix_in;
   end

   // Histogram memory; a bin whose valid bit is low reads as zero
   assign bin_addr = cmd.hist_rd ? pix_ff : x_ff;
   assign bin_eff  = bin_rd_vld_ff ? bin_rd_ff : '0;
   assign bin_inc  = (bin_eff == '1) ? bin_eff : bin_eff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.hist_rd || cmd.bin_rd) bin_rd_ff <= bin_mem[bin_addr];
      if (cmd.cnt_wr) bin_mem[pix_ff] <= bin_inc;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_hist) begin
         bin_vld_ff <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
      end else if (cmd.cnt_wr) begin
         bin_vld_ff[pix_ff] <= 1'b1;
         if (pix_ff <= split_lvl) begin
            if (low_ff != '1) low_ff <= low_ff + 1'b1;
         end else begin
            if (high_ff != '1) high_ff <= high_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_rd_vld_ff <= 1'b0;
      end else if (cmd.hist_rd || cmd.bin_rd) begin
         bin_rd_vld_ff <= bin_vld_ff[bin_addr];
      end
   end

   // Part bounds and build level
   always_ff @(posedge clock) begin
      if (cmd.part_init) begin
         cdf_ff <= '0;
         if (!cmd.part_sel) begin
            lo_ff <= '0;
            x_ff  <= '0;
            hi_ff <= mode_ff ? split_lvl : TOP_LVL;
            n_ff  <= mode_ff ? {1'b0, low_ff} : {1'b0, low_ff} + {1'b0, high_ff};
         end else begin
            lo_ff <= split_lvl + 1'b1;
            x_ff  <= split_lvl + 1'b1;
            hi_ff <= TOP_LVL;
            n_ff  <= {1'b0, high_ff};
         end
      end else begin
         if (cmd.cdf_acc) cdf_ff <= cdf_ff + CDF_BITS'(bin_eff);
         if (cmd.map_wr)  x_ff   <= x_ff + 1'b1;
      end
   end

   // Span times cdf
   assign span = hi_ff - lo_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PROD_BITS'(span) * PROD_BITS'(cdf_ff);
   end

   // Restoring divider, one quotient bit a cycle; a high part at or above n
   // means the quotient cannot fit the level width and is clamped
   assign prod_top = prod_ff[PROD_BITS-1:LVL_BITS];
   assign trial    = {rem_ff, frac_ff[LVL_BITS-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         ovf_ff  <= (prod_top >= CDF_BITS'(n_ff));
         rem_ff  <= prod_top[N_BITS-1:0];
         frac_ff <= prod_ff[LVL_BITS-1:0];
         q_ff    <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         frac_ff <= frac_ff << 1;
         step_ff <= step_ff + 1'b1;
         if (trial >= {1'b0, n_ff}) begin
            rem_ff <= N_BITS'(trial - {1'b0, n_ff});
            q_ff   <= {q_ff[LVL_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[N_BITS-1:0];
            q_ff   <= {q_ff[LVL_BITS-2:0], 1'b0};
         end
      end
   end

   // Map entry: empty part gives its lower bound, overflow clamps to the upper
   always_comb begin
      if (n_ff == '0)                     map_val = lo_ff;
      else if (ovf_ff || (q_ff > span))   map_val = hi_ff;
      else                                map_val = lo_ff + q_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.map_wr)   map_mem[x_ff] <= 8'(map_val);
      if (cmd.map_rd)   map_rd_ff     <= map_mem[pix_ff];
      if (cmd.rsp_load) rsp_pixel_ff  <= map_rd_ff;
   end

   assign rsp_mapped_pixel   = rsp_pixel_ff;
   assign status.x_last      = (x_ff == hi_ff);
   assign status.div_last    = (step_ff == STEP_BITS'(LVL_BITS - 1));
   assign status.has_part1   = mode_ff && (split_lvl != TOP_LVL);

endmodule

[design/bhe_ctrl.sv]
// Controller of the bi-histogram equalizer: item sequencing, build walk, result handshake.
// Depends on bhe_pkg.
`timescale 1ns / 1ps

module bhe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_kind,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bhe_pkg::bhe_status_type status,
   output bhe_pkg::bhe_cmd_type    cmd
);
   import bhe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_CNT_RD, S_CNT_WR, S_MAP_RD, S_MAP_OUT,
      S_PART, S_BRD, S_BACC, S_BMUL, S_BDIV0, S_BDIV, S_BWR
   } state_type;

   state_type state_ff;
   logic      part_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Command decode from state
   always_comb begin
      cmd           = '0;
      cmd.load_item = accept;
      cmd.part_sel  = part_ff;
      case (state_ff)
         S_CLR:     cmd.clr_hist  = 1'b1;
         S_CNT_RD:  cmd.hist_rd   = 1'b1;
         S_CNT_WR:  cmd.cnt_wr    = 1'b1;
         S_MAP_RD:  cmd.map_rd    = 1'b1;
         S_MAP_OUT: cmd.rsp_load  = out_free;
         S_PART:    cmd.part_init = 1'b1;
         S_BRD:     cmd.bin_rd    = 1'b1;
         S_BACC:    cmd.cdf_acc   = 1'b1;
         S_BMUL:    cmd.mul       = 1'b1;
         S_BDIV0:   cmd.div_init  = 1'b1;
         S_BDIV:    cmd.div_step  = 1'b1;
         S_BWR:     cmd.map_wr    = 1'b1;
         default:   cmd.load_item = accept;
      endcase
   end

   // State, part index and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         part_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_kind)
                     KIND_CLEAR: state_ff <= S_CLR;
                     KIND_COUNT: state_ff <= S_CNT_RD;
                     KIND_BUILD: begin
                        state_ff <= S_PART;
                        part_ff  <= 1'b0;
                     end
                     KIND_MAP:   state_ff <= S_MAP_RD;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CLR:    state_ff <= S_IDLE;
            S_CNT_RD: state_ff <= S_CNT_WR;
            S_CNT_WR: state_ff <= S_IDLE;
            S_MAP_RD: state_ff <= S_MAP_OUT;
            S_MAP_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_PART:  state_ff <= S_BRD;
            S_BRD:   state_ff <= S_BACC;
            S_BACC:  state_ff <= S_BMUL;
            S_BMUL:  state_ff <= S_BDIV0;
            S_BDIV0: state_ff <= S_BDIV;
            S_BDIV: begin
               if (status.div_last) state_ff <= S_BWR;
            end
            S_BWR: begin
               if (!status.x_last) begin
                  state_ff <= S_BRD;
               end else if (!part_ff && status.has_part1) begin
                  part_ff  <= 1'b1;
                  state_ff <= S_PART;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[design/bi_histogram_equalizer_unit.sv]
// Top level of the bi-histogram equalizer: controller plus datapath.
// Depends on bhe_pkg, bhe_ctrl, bhe_dpath.
//
// Usage:
//  - Request channel (req_valid/req_ready, req_kind, req_pixel) takes one item at a time:
//    clear, count pixel, build map, or map pixel.
//  - Result channel (rsp_valid/rsp_ready, rsp_mapped_pixel) returns one item per map item.
//  - CSR channel (csr_valid/csr_ready, csr_index, csr_data) is always ready; index 0 is
//    split mode, index 1 the split level. Write it only while the block is idle.
//  - Item steps: clear empties the histogram and part counts; count reads the bin, then
//    writes it incremented; map reads the map entry, then loads the result register.
//    Build walks every gray level through the one multiplier and a one-bit-a-cycle
//    divider: per level bin read, cdf add, multiply, divider load, divide, map write.
//  - Reset clears the histogram (per-bin valid bits) and part counts and sets the CSRs
//    to split mode off, level 128; the map table holds nothing until the first build.
//  - A result waits in its output register while the receiver stalls; the next item is
//    still accepted, and a following map item waits for the register to free.
`timescale 1ns / 1ps

module bi_histogram_equalizer_unit #(
   parameter int COUNT_BITS  = 22,
   parameter int GRAY_LEVELS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_mapped_pixel,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import bhe_pkg::*;

   bhe_cmd_type    cmd;
   bhe_status_type status;

   assign csr_ready = 1'b1;

   bhe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bhe_dpath #(
      .COUNT_BITS  (COUNT_BITS),
      .GRAY_LEVELS (GRAY_LEVELS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel        (req_pixel),
      .cmd              (cmd),
      .status           (status),
      .rsp_mapped_pixel (rsp_mapped_pixel)
   );

endmodule

[sim/tb.sv]
// Self-checking testbench of bi_histogram_equalizer_unit: directed and random phases.
// Predicts mapped pixels from its own histogram and map table. Depends on bhe_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import bhe_pkg::*;

   localparam int LEVELS   = 256;
   localparam int CNT_W    = 22;
   localparam int TOP      = LEVELS - 1;
   localparam int SETTLE   = 20;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] pixel;
   } pixel_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = KIND_CLEAR;
   logic [7:0] req_pixel = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_mapped_pixel;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_SPLIT_MODE;
   logic [7:0] csr_data = '0;

   // Stimulus and expectation stores
   pixel_item_type pending_items[$];
   logic [7:0]     expected_pixels[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             errors = 0;

   // Predicted block state
   logic [CNT_W-1:0] hist_bins[LEVELS];
   logic [CNT_W-1:0] low_count, high_count;
   logic [7:0]       eq_map[LEVELS];
   logic             mode_split;
   logic [7:0]       split_at;

   bi_histogram_equalizer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mapped_pixel(rsp_mapped_pixel),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [CNT_W-1:0] sat_add1(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Fill map entries lo..hi from the running cdf of that part
   task automatic equalize_part(int lo, int hi, longint n);
      longint cdf;
      longint v;
      cdf = 0;
      for (int x = lo; x <= hi; x++) begin
         cdf += hist_bins[x];
         v = lo;
         if (n != 0) begin
            v = lo + (longint'(hi - lo) * cdf) / n;
            if (v > hi) v = hi;
         end
         eq_map[x] = v[7:0];
      end
   endtask

   // Update state for one accepted item; returns whether it gives a result
   task automatic predict_item(input pixel_item_type it, output bit has_rsp,
                               output logic [7:0] mapped);
      int s;
      has_rsp = 0;
      mapped = '0;
      s = split_at;
      case (it.kind)
         KIND_CLEAR: begin
            foreach (hist_bins[i]) hist_bins[i] = '0;
            low_count = '0;
            high_count = '0;
         end
         KIND_COUNT: begin
            hist_bins[it.pixel] = sat_add1(hist_bins[it.pixel]);
            if (it.pixel <= split_at) low_count = sat_add1(low_count);
            else high_count = sat_add1(high_count);
         end
         KIND_BUILD: begin
            if (!mode_split) equalize_part(0, TOP, longint'(low_count) + high_count);
            else begin
               equalize_part(0, s, low_count);
               if (s < TOP) equalize_part(s + 1, TOP, high_count);
            end
         end
         default: begin
            has_rsp = 1;
            mapped = eq_map[it.pixel];
         end
      endcase
   endtask

   // Request driver: valid holds until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_kind  <= pending_items[0].kind;
            req_pixel <= pending_items[0].pixel;
            req_valid <= 1'b1;
            void'(pending_items.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      pixel_item_type it;
      bit has_rsp;
      logic [7:0] mapped;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it.kind = req_kind;
            it.pixel = req_pixel;
            predict_item(it, has_rsp, mapped);
            if (has_rsp) expected_pixels.push_back(mapped);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, actual mapped_pixel %0d",
                        $time, rsp_mapped_pixel);
               errors++;
            end else begin
               if (rsp_mapped_pixel !== expected_pixels[0]) begin
                  $display("%0t: mapped_pixel mismatch, expected %0d actual %0d",
                           $time, expected_pixels[0], rsp_mapped_pixel);
                  errors++;
               end
               void'(expected_pixels.pop_front());
            end
         end
      end
   end

   task automatic add_item(logic [1:0] kind, logic [7:0] pixel);
      pixel_item_type it;
      it.kind = kind;
      it.pixel = pixel;
      pending_items.push_back(it);
   endtask

   // Wait until all items are accepted and all results are back
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SPLIT_MODE) mode_split = data[0];
      else split_at = data;
   endtask

   // Timeout
   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus
   initial begin
      int n_cnt;
      int n_map;
      int band_lo;
      int band_w;
      int pct_idx;
      logic [7:0] lvl;
      foreach (hist_bins[i]) hist_bins[i] = '0;
      foreach (eq_map[i]) eq_map[i] = '0;
      low_count = '0;
      high_count = '0;
      mode_split = 1'b0;
      split_at = 8'd128;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty histogram, extremes, split and inconsistent counts
      add_item(KIND_BUILD, 8'd0);
      add_item(KIND_MAP, 8'd0);
      add_item(KIND_MAP, 8'd255);
      add_item(KIND_CLEAR, 8'd0);
      add_item(KIND_COUNT, 8'd0);
      add_item(KIND_COUNT, 8'd255);
      add_item(KIND_COUNT, 8'd128);
      add_item(KIND_COUNT, 8'd129);
      add_item(KIND_COUNT, 8'd128);
      add_item(KIND_BUILD, 8'd0);
      add_item(KIND_MAP, 8'd0);
      add_item(KIND_MAP, 8'd128);
      add_item(KIND_MAP, 8'd129);
      add_item(KIND_MAP, 8'd255);
      drain();
      write_csr(CSR_SPLIT_MODE, 8'd1);
      add_item(KIND_BUILD, 8'd0);
      add_item(KIND_MAP, 8'd128);
      add_item(KIND_MAP, 8'd129);
      drain();
      // split level moved after counting
      write_csr(CSR_SPLIT_LEVEL, 8'd0);
      add_item(KIND_BUILD, 8'd0);
      add_item(KIND_MAP, 8'd0);
      add_item(KIND_MAP, 8'd1);
      add_item(KIND_MAP, 8'd255);
      add_item(KIND_CLEAR, 8'd0);
      add_item(KIND_BUILD, 8'd0);
      add_item(KIND_MAP, 8'd200);
      drain();

      // Random phases: configure, clear, count, build, map
      for (int ph = 0; ph < 20; ph++) begin
         pct_idx = ph % 4;
         send_idle_pct  = (pct_idx == 1 || pct_idx == 3) ? ((pct_idx == 1) ? 79 : 9) : 0;
         recv_stall_pct = (pct_idx == 2 || pct_idx == 3) ? ((pct_idx == 2) ? 79 : 9) : 0;
         write_csr(CSR_SPLIT_MODE, 8'($urandom_range(1)) | 8'($urandom_range(255)) << 1);
         case ($urandom_range(5))
            0: lvl = 8'd0;
            1: lvl = 8'd254;
            2: lvl = 8'd255;
            default: lvl = 8'($urandom_range(255));
         endcase
         write_csr(CSR_SPLIT_LEVEL, lvl);
         if ($urandom_range(9) != 0) add_item(KIND_CLEAR, 8'($urandom_range(255)));
         n_cnt = $urandom_range(15, 35);
         band_lo = $urandom_range(255);
         band_w = ($urandom_range(1) != 0) ? 255 : $urandom_range(1, 40);
         for (int i = 0; i < n_cnt; i++)
            add_item(KIND_COUNT, 8'((band_lo + $urandom_range(band_w)) % LEVELS));
         add_item(KIND_BUILD, 8'($urandom_range(255)));
         n_map = $urandom_range(8, 14);
         for (int i = 0; i < n_map; i++) begin
            // occasional stray clear or count between lookups
            if ($urandom_range(19) == 0)
               add_item(($urandom_range(1) != 0) ? KIND_CLEAR : KIND_COUNT,
                        8'($urandom_range(255)));
            add_item(KIND_MAP, 8'($urandom_range(255)));
         end
         drain();
      end

      repeat (50) @(negedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (expected_pixels.size() != 0)
            $display("%0t: %0d results never arrived, expected next %0d",
                     $time, expected_pixels.size(), expected_pixels[0]);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
design/bhe_pkg.sv
design/bhe_dpath.sv
design/bhe_ctrl.sv
design/bi_histogram_equalizer_unit.sv
sim/tb.sv
